// ===== rtl/crc32_image_check_defines.svh =====
// Assertion macros used by the checker file of the image checksum block.
`ifndef CRC32_IMAGE_CHECK_DEFINES_SVH
`define CRC32_IMAGE_CHECK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CIC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crc32 image check: same-cycle rule violated");

// Next-cycle implication, checked outside reset.
`define CIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crc32 image check: next-cycle rule violated");

// Next-cycle implication that also holds through reset.
`define CIC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("crc32 image check: reset rule violated");

`endif

// ===== rtl/crc32ic_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32ic_pkg
// Constants, codes and the byte-wise CRC step of the image checksum block.
// ----------------------------------------------------------------------------
package crc32ic_pkg;

    localparam int CRC_W = 32;
    localparam int CNT_W = 32;
    localparam int CFG_NUM = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [1:0]       verdict_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam crc_t CRC_SEED   = 32'hFFFF_FFFF;
    localparam crc_t CRC_XOROUT = 32'hFFFF_FFFF;
    localparam crc_t CRC_POLY   = 32'h1EDC_6F41;

    // Register indexes
    localparam cfg_idx_t CFG_KNOWN_A  = 3'd0;
    localparam cfg_idx_t CFG_KNOWN_B  = 3'd1;
    localparam cfg_idx_t CFG_EXTRA_0  = 3'd2;
    localparam cfg_idx_t CFG_EXTRA_1  = 3'd3;
    localparam cfg_idx_t CFG_EXTRA_2  = 3'd4;
    localparam cfg_idx_t CFG_EXTRA_3  = 3'd5;
    localparam cfg_idx_t CFG_EXP_LEN  = 3'd6;

    // Register reset values
    localparam crc_t KNOWN_A_RST = 32'hE168_0293;
    localparam crc_t KNOWN_B_RST = 32'hEF34_F989;
    localparam crc_t EXTRA_RST   = 32'h0000_0000;
    localparam logic [CNT_W-1:0] EXP_LEN_RST = 32'd1189888;

    // Verdict codes
    localparam verdict_t VERDICT_KNOWN  = 2'd0;
    localparam verdict_t VERDICT_EXTRA  = 2'd1;
    localparam verdict_t VERDICT_LENGTH = 2'd2;
    localparam verdict_t VERDICT_REJECT = 2'd3;

    // Eight reflected shift steps over one byte
    function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] data);
        crc_t c;
        c = crc ^ {{(CRC_W-8){1'b0}}, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc32_image_check.sv =====
// ----------------------------------------------------------------------------
// crc32_image_check
// Running image checksum with a verdict against stored values and a length.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one image byte per item, s_last_byte marking the
//   final byte. Each byte updates a reflected 32-bit CRC (seed all ones,
//   constant 0x1EDC6F41) and a saturating byte count.
//   On the final byte the m_ channel gives one item: the inverted CRC and a
//   verdict (known match, extra match, length-only match, reject); then the
//   CRC and count re-arm for the next image.
//   The cfg_ channel writes the seven compare registers by index; indexes
//   beyond the list are dropped. Write only while no image is in flight.
// Timing:
//   One byte per cycle while no final byte waits. A byte is held in the input
//   register; the CRC step and compares run between that register and the
//   result register, so a result is registered straight from the input
//   register when the result slot is free or its result is being taken.
//   If the receiver stalls, bytes of the next image still flow through;
//   only a second final byte waits in the input register, and s_ready drops
//   until the pending result is taken.
// Reset:
//   Synchronous, active low. Clears both registers' valid flags, seeds the
//   CRC, zeroes the count and loads the compare registers' defaults.
// ----------------------------------------------------------------------------
module crc32_image_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input bytes
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_last_byte,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output crc32ic_pkg::crc_t              m_crc_value,
    output crc32ic_pkg::verdict_t          m_verdict,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  crc32ic_pkg::cfg_idx_t          cfg_index,
    input  logic [crc32ic_pkg::CRC_W-1:0]  cfg_data
);
    import crc32ic_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    crc_t              crc_reg, crc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    crc_t              out_crc_reg;
    verdict_t          out_verdict_reg;
    crc_t              cfg_reg [CFG_NUM];

    logic              advance;
    crc_t              crc_step;
    crc_t              crc_final;
    logic [CNT_W-1:0]  cnt_step;
    logic              known_hit;
    logic              extra_hit;
    verdict_t          verdict;

    // Move the held byte on unless it is final and the result slot is full and not being taken
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // CRC step, saturating count and verdict for the held byte
    always_comb begin
        crc_step  = crc_byte(crc_reg, in_data_reg);
        cnt_step  = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
        crc_final = crc_step ^ CRC_XOROUT;
        known_hit = (crc_final == cfg_reg[CFG_KNOWN_A]) || (crc_final == cfg_reg[CFG_KNOWN_B]);
        extra_hit = ((cfg_reg[CFG_EXTRA_0] != '0) && (crc_final == cfg_reg[CFG_EXTRA_0]))
                 || ((cfg_reg[CFG_EXTRA_1] != '0) && (crc_final == cfg_reg[CFG_EXTRA_1]))
                 || ((cfg_reg[CFG_EXTRA_2] != '0) && (crc_final == cfg_reg[CFG_EXTRA_2]))
                 || ((cfg_reg[CFG_EXTRA_3] != '0) && (crc_final == cfg_reg[CFG_EXTRA_3]));
        if (known_hit) begin
            verdict = VERDICT_KNOWN;
        end else if (extra_hit) begin
            verdict = VERDICT_EXTRA;
        end else if (cnt_step == cfg_reg[CFG_EXP_LEN]) begin
            verdict = VERDICT_LENGTH;
        end else begin
            verdict = VERDICT_REJECT;
        end
    end

    // Next running state: re-arm after the final byte
    always_comb begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (advance) begin
            crc_next = in_last_reg ? CRC_SEED : crc_step;
            cnt_next = in_last_reg ? '0 : cnt_step;
        end
    end

    // Result slot: drain on take, fill on a final byte
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    // Control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_SEED;
            cnt_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance && in_last_reg) begin
            out_crc_reg     <= crc_final;
            out_verdict_reg <= verdict;
        end
    end

    // Compare registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[CFG_KNOWN_A] <= KNOWN_A_RST;
            cfg_reg[CFG_KNOWN_B] <= KNOWN_B_RST;
            cfg_reg[CFG_EXTRA_0] <= EXTRA_RST;
            cfg_reg[CFG_EXTRA_1] <= EXTRA_RST;
            cfg_reg[CFG_EXTRA_2] <= EXTRA_RST;
            cfg_reg[CFG_EXTRA_3] <= EXTRA_RST;
            cfg_reg[CFG_EXP_LEN] <= EXP_LEN_RST;
        end else if (cfg_valid && cfg_ready && (cfg_index <= CFG_EXP_LEN)) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;
    assign m_verdict   = out_verdict_reg;

endmodule

// ===== rtl/crc32ic_checker.sv =====
// ----------------------------------------------------------------------------
// crc32ic_checker
// Port-level checks of the image checksum block, bound to its top level.
// ----------------------------------------------------------------------------
`include "crc32_image_check_defines.svh"

module crc32ic_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input crc32ic_pkg::crc_t              m_crc_value,
    input crc32ic_pkg::verdict_t          m_verdict
);
    import crc32ic_pkg::*;

    logic                 pending;
    logic [CRC_W+1:0]     res_bits;

    assign pending  = m_valid && !m_ready;
    assign res_bits = {m_crc_value, m_verdict};

    // Input stalls only behind an untaken result
    `CIC_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, pending)

    // A pending result holds its value
    `CIC_ASSERT_NEXT(a_result_hold, aclk, aresetn, pending, m_valid && $stable(res_bits))

    // An extra match never reports a zero checksum
    `CIC_ASSERT_NOW(a_extra_nonzero, aclk, aresetn, m_valid && (m_verdict == VERDICT_EXTRA), m_crc_value != '0)

    // Reset leaves no result and an open input
    `CIC_ASSERT_ALWAYS_NEXT(a_reset_state, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind crc32_image_check crc32ic_checker u_crc32ic_checker (.*);
